### hdl/smmr_pkg.sv
// Shared types and constants for the series min/max/mean/run statistics block.
`default_nettype none

package smmr_pkg;

  // Fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int THR_W    = 16;
  localparam int TOTAL_W  = 11;
  localparam int POS_W    = 10;
  localparam int MEAN_W   = 16;

  // Parameter defaults
  localparam int DEF_MAX_SAMPLES = 1024;
  localparam int DEF_SAMPLE_BITS = 16;

  // Register file
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_RUN_THRESHOLD = 1'b0;
  localparam logic [THR_W-1:0]     THR_RESET         = 16'd500;

  // Shared unit operation
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MIN,
    ST_MAX,
    ST_THR,
    ST_RUN,
    ST_SUM,
    ST_DIV,
    ST_RND,
    ST_INC,
    ST_PUSH
  } state_t;

endpackage

`default_nettype wire

### hdl/smmr_alu.sv
// Shared adder/subtractor used for every compare, add and divide step.
`default_nettype none

module smmr_alu #(
  parameter int W = 32
) (
  input  var smmr_pkg::alu_op_t op,
  input  wire logic [W-1:0]     a,
  input  wire logic [W-1:0]     b,
  output logic      [W-1:0]     res,
  output logic                  carry,
  output logic                  zero
);

  logic [W-1:0] b_eff;
  logic [W:0]   full;
  logic         cin;

  // a - b is a + ~b + 1; carry set means a >= b on subtract
  always_comb begin
    cin   = (op == smmr_pkg::ALU_SUB);
    b_eff = cin ? ~b : b;
    full  = {1'b0, a} + {1'b0, b_eff} + {{W{1'b0}}, cin};
    res   = full[W-1:0];
    carry = full[W];
    zero  = (full[W-1:0] == '0);
  end

endmodule

`default_nettype wire

### hdl/smmr_cfg.sv
// APB-style register file holding the run threshold.
`default_nettype none

module smmr_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [smmr_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [smmr_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic      [smmr_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                   pready,
  output logic      [smmr_pkg::THR_W-1:0]        run_threshold
);

  logic [smmr_pkg::THR_W-1:0]     thr_r;
  logic [smmr_pkg::THR_W-1:0]     thr_nxt;
  logic [smmr_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           wr_en;

  assign pready        = 1'b1;
  assign run_threshold = thr_r;

  // Word index from byte address
  assign reg_idx = paddr[smmr_pkg::CFG_ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;

  always_comb begin
    thr_nxt = thr_r;
    if (wr_en && reg_idx == smmr_pkg::REG_RUN_THRESHOLD) begin
      thr_nxt = pwdata[smmr_pkg::THR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= smmr_pkg::THR_RESET;
    end else begin
      thr_r <= thr_nxt;
    end
  end

  // Readback
  always_comb begin
    if (reg_idx == smmr_pkg::REG_RUN_THRESHOLD) begin
      prdata = smmr_pkg::CFG_DATA_W'(thr_r);
    end else begin
      prdata = '0;
    end
  end

endmodule

`default_nettype wire

### hdl/series_min_max_mean_run.sv
// Top level: running min/max, mean and longest above-threshold run over a sample series.
`default_nettype none

// Each accepted sample is folded into the series statistics by a small sequencer that
// drives one shared adder/subtractor: min compare, max compare, threshold compare,
// run-length compare (only when the sample is above the threshold) and the sum add.
// A sample therefore occupies the input while these steps run; a sample arriving after the
// series holds MAX_SAMPLES entries is dropped without them. A sample marked last then
// runs a restoring division of the sum by the count on the same unit, one quotient bit
// per cycle, followed by the round-half-even decision, an increment when rounding up,
// and a step that hands the result to the output register. in_stall is high for the
// whole time. The result waits in the output register, so the next series may start
// while it is still stalled. The series state clears as the result is loaded;
// run_threshold keeps its value.
module series_min_max_mean_run #(
  parameter int MAX_SAMPLES = smmr_pkg::DEF_MAX_SAMPLES,
  parameter int SAMPLE_BITS = smmr_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [smmr_pkg::SAMPLE_W-1:0]     in_step_sample,
  input  wire logic                              in_last_sample,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [smmr_pkg::TOTAL_W-1:0]      out_sample_total,
  output logic      [smmr_pkg::POS_W-1:0]        out_min_position,
  output logic      [smmr_pkg::POS_W-1:0]        out_max_position,
  output logic      [smmr_pkg::MEAN_W-1:0]       out_mean_value,
  output logic                                   out_run_found,
  output logic      [smmr_pkg::POS_W-1:0]        out_run_first,
  output logic      [smmr_pkg::POS_W-1:0]        out_run_final,
  // configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [smmr_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [smmr_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic      [smmr_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                   pready
);

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int IDX_W  = $clog2(MAX_SAMPLES);
  localparam int SB     = SAMPLE_BITS;
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int ALU_W  = ((SUM_W > smmr_pkg::THR_W) ? SUM_W : smmr_pkg::THR_W) + 1;
  localparam int DIV_W  = $clog2(SUM_W);
  localparam logic [DIV_W-1:0] DIV_LAST = DIV_W'(SUM_W - 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_SAMPLES);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  logic [smmr_pkg::THR_W-1:0] run_threshold;

  // Register file
  smmr_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .run_threshold (run_threshold)
  );

  // Sequencer and series state
  smmr_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SB-1:0]    min_r, min_nxt;
  logic [SB-1:0]    max_r, max_nxt;
  logic [IDX_W-1:0] min_idx_r, min_idx_nxt;
  logic [IDX_W-1:0] max_idx_r, max_idx_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] run_start_r, run_start_nxt;
  logic [CNT_W-1:0] run_len_r, run_len_nxt;
  logic [CNT_W-1:0] best_len_r, best_len_nxt;
  logic [IDX_W-1:0] best_start_r, best_start_nxt;
  logic [IDX_W-1:0] best_end_r, best_end_nxt;

  // Working registers
  logic [SB-1:0]    samp_r, samp_nxt;
  logic             last_r, last_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] div_cnt_r, div_cnt_nxt;

  // Output register
  logic                            out_valid_r, out_valid_nxt;
  logic [smmr_pkg::TOTAL_W-1:0]    total_r, total_nxt;
  logic [smmr_pkg::POS_W-1:0]      min_pos_r, min_pos_nxt;
  logic [smmr_pkg::POS_W-1:0]      max_pos_r, max_pos_nxt;
  logic [smmr_pkg::MEAN_W-1:0]     mean_r, mean_nxt;
  logic                            found_r, found_nxt;
  logic [smmr_pkg::POS_W-1:0]      first_r, first_nxt;
  logic [smmr_pkg::POS_W-1:0]      final_r, final_nxt;

  // Shared unit
  smmr_pkg::alu_op_t alu_op;
  logic [ALU_W-1:0]  alu_a;
  logic [ALU_W-1:0]  alu_b;
  logic [ALU_W-1:0]  alu_res;
  logic              alu_carry;
  logic              alu_zero;

  smmr_alu #(
    .W (ALU_W)
  ) u_alu (
    .op    (alu_op),
    .a     (alu_a),
    .b     (alu_b),
    .res   (alu_res),
    .carry (alu_carry),
    .zero  (alu_zero)
  );

  logic [31:0]      in_ext;
  logic [31:0]      cnt_ext;
  logic [31:0]      min_idx_ext;
  logic [31:0]      max_idx_ext;
  logic [31:0]      best_start_ext;
  logic [31:0]      best_end_ext;
  logic [63:0]      sum_ext;
  logic [IDX_W-1:0] cur_idx;
  logic             cnt_zero;
  logic             cnt_full;
  logic             run_any;

  assign in_ext         = 32'(in_step_sample);
  assign cnt_ext        = 32'(cnt_r);
  assign min_idx_ext    = 32'(min_idx_r);
  assign max_idx_ext    = 32'(max_idx_r);
  assign best_start_ext = 32'(best_start_r);
  assign best_end_ext   = 32'(best_end_r);
  assign sum_ext        = 64'(sum_r);
  assign cur_idx        = cnt_r[IDX_W-1:0];
  assign cnt_zero       = (cnt_r == '0);
  assign cnt_full       = (cnt_r == CNT_MAX);
  assign run_any        = (best_len_r != '0);

  assign in_stall         = (state_r != smmr_pkg::ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_sample_total = total_r;
  assign out_min_position = min_pos_r;
  assign out_max_position = max_pos_r;
  assign out_mean_value   = mean_r;
  assign out_run_found    = found_r;
  assign out_run_first    = first_r;
  assign out_run_final    = final_r;

  // Next state, shared unit operands and register updates
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    min_nxt        = min_r;
    max_nxt        = max_r;
    min_idx_nxt    = min_idx_r;
    max_idx_nxt    = max_idx_r;
    sum_nxt        = sum_r;
    run_start_nxt  = run_start_r;
    run_len_nxt    = run_len_r;
    best_len_nxt   = best_len_r;
    best_start_nxt = best_start_r;
    best_end_nxt   = best_end_r;
    samp_nxt       = samp_r;
    last_nxt       = last_r;
    rem_nxt        = rem_r;
    div_cnt_nxt    = div_cnt_r;
    out_valid_nxt  = out_valid_r & out_stall;
    total_nxt      = total_r;
    min_pos_nxt    = min_pos_r;
    max_pos_nxt    = max_pos_r;
    mean_nxt       = mean_r;
    found_nxt      = found_r;
    first_nxt      = first_r;
    final_nxt      = final_r;
    alu_op         = smmr_pkg::ALU_SUB;
    alu_a          = '0;
    alu_b          = '0;

    unique case (state_r)
      smmr_pkg::ST_IDLE: begin
        if (in_valid) begin
          samp_nxt = in_ext[SB-1:0];
          last_nxt = in_last_sample;
          if (!cnt_full) begin
            state_nxt = smmr_pkg::ST_MIN;
          end else if (in_last_sample) begin
            // series full: sample dropped, result still due
            rem_nxt     = '0;
            div_cnt_nxt = '0;
            state_nxt   = smmr_pkg::ST_DIV;
          end
        end
      end

      // new minimum when sample < min (first sample always)
      smmr_pkg::ST_MIN: begin
        alu_a = ALU_W'(samp_r);
        alu_b = ALU_W'(min_r);
        if (cnt_zero || !alu_carry) begin
          min_nxt     = samp_r;
          min_idx_nxt = cur_idx;
        end
        state_nxt = smmr_pkg::ST_MAX;
      end

      // new maximum when max < sample
      smmr_pkg::ST_MAX: begin
        alu_a = ALU_W'(max_r);
        alu_b = ALU_W'(samp_r);
        if (cnt_zero || !alu_carry) begin
          max_nxt     = samp_r;
          max_idx_nxt = cur_idx;
        end
        state_nxt = smmr_pkg::ST_THR;
      end

      // above threshold when threshold < sample
      smmr_pkg::ST_THR: begin
        alu_a = ALU_W'(run_threshold);
        alu_b = ALU_W'(samp_r);
        if (!alu_carry) begin
          run_len_nxt = run_len_r + CNT_ONE;
          state_nxt   = smmr_pkg::ST_RUN;
        end else begin
          run_start_nxt = cnt_r + CNT_ONE;
          run_len_nxt   = '0;
          state_nxt     = smmr_pkg::ST_SUM;
        end
      end

      // strictly longer run replaces the best, so the earliest one wins ties
      smmr_pkg::ST_RUN: begin
        alu_a = ALU_W'(best_len_r);
        alu_b = ALU_W'(run_len_r);
        if (!alu_carry) begin
          best_len_nxt   = run_len_r;
          best_start_nxt = run_start_r[IDX_W-1:0];
          best_end_nxt   = cur_idx;
        end
        state_nxt = smmr_pkg::ST_SUM;
      end

      smmr_pkg::ST_SUM: begin
        alu_op  = smmr_pkg::ALU_ADD;
        alu_a   = ALU_W'(sum_r);
        alu_b   = ALU_W'(samp_r);
        sum_nxt = alu_res[SUM_W-1:0];
        cnt_nxt = cnt_r + CNT_ONE;
        if (last_r) begin
          rem_nxt     = '0;
          div_cnt_nxt = '0;
          state_nxt   = smmr_pkg::ST_DIV;
        end else begin
          state_nxt = smmr_pkg::ST_IDLE;
        end
      end

      // restoring division, quotient shifts into the sum register
      smmr_pkg::ST_DIV: begin
        alu_a = ALU_W'({rem_r, sum_r[SUM_W-1]});
        alu_b = ALU_W'(cnt_r);
        if (alu_carry) begin
          rem_nxt = alu_res[CNT_W-1:0];
        end else begin
          rem_nxt = {rem_r[CNT_W-2:0], sum_r[SUM_W-1]};
        end
        sum_nxt     = {sum_r[SUM_W-2:0], alu_carry};
        div_cnt_nxt = div_cnt_r + DIV_W'(1);
        if (div_cnt_r == DIV_LAST) begin
          state_nxt = smmr_pkg::ST_RND;
        end
      end

      // round up when 2r > n, or 2r == n with odd quotient
      smmr_pkg::ST_RND: begin
        alu_a = ALU_W'(cnt_r);
        alu_b = ALU_W'({rem_r, 1'b0});
        if (!alu_carry || (alu_zero && sum_r[0])) begin
          state_nxt = smmr_pkg::ST_INC;
        end else begin
          state_nxt = smmr_pkg::ST_PUSH;
        end
      end

      smmr_pkg::ST_INC: begin
        alu_op    = smmr_pkg::ALU_ADD;
        alu_a     = ALU_W'(sum_r);
        alu_b     = ALU_W'(1);
        sum_nxt   = alu_res[SUM_W-1:0];
        state_nxt = smmr_pkg::ST_PUSH;
      end

      // load output register once free, then clear the series
      smmr_pkg::ST_PUSH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          total_nxt      = cnt_ext[smmr_pkg::TOTAL_W-1:0];
          min_pos_nxt    = min_idx_ext[smmr_pkg::POS_W-1:0];
          max_pos_nxt    = max_idx_ext[smmr_pkg::POS_W-1:0];
          mean_nxt       = sum_ext[smmr_pkg::MEAN_W-1:0];
          found_nxt      = run_any;
          first_nxt      = run_any ? best_start_ext[smmr_pkg::POS_W-1:0] : '0;
          final_nxt      = run_any ? best_end_ext[smmr_pkg::POS_W-1:0] : '0;
          cnt_nxt        = '0;
          min_nxt        = '0;
          max_nxt        = '0;
          min_idx_nxt    = '0;
          max_idx_nxt    = '0;
          sum_nxt        = '0;
          run_start_nxt  = '0;
          run_len_nxt    = '0;
          best_len_nxt   = '0;
          best_start_nxt = '0;
          best_end_nxt   = '0;
          state_nxt      = smmr_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = smmr_pkg::ST_IDLE;
      end
    endcase
  end

  // Control and series state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= smmr_pkg::ST_IDLE;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
      min_r        <= '0;
      max_r        <= '0;
      min_idx_r    <= '0;
      max_idx_r    <= '0;
      sum_r        <= '0;
      run_start_r  <= '0;
      run_len_r    <= '0;
      best_len_r   <= '0;
      best_start_r <= '0;
      best_end_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      cnt_r        <= cnt_nxt;
      min_r        <= min_nxt;
      max_r        <= max_nxt;
      min_idx_r    <= min_idx_nxt;
      max_idx_r    <= max_idx_nxt;
      sum_r        <= sum_nxt;
      run_start_r  <= run_start_nxt;
      run_len_r    <= run_len_nxt;
      best_len_r   <= best_len_nxt;
      best_start_r <= best_start_nxt;
      best_end_r   <= best_end_nxt;
    end
  end

  // Payload and scratch registers
  always_ff @(posedge clk) begin
    samp_r    <= samp_nxt;
    last_r    <= last_nxt;
    rem_r     <= rem_nxt;
    div_cnt_r <= div_cnt_nxt;
    total_r   <= total_nxt;
    min_pos_r <= min_pos_nxt;
    max_pos_r <= max_pos_nxt;
    mean_r    <= mean_nxt;
    found_r   <= found_nxt;
    first_r   <= first_nxt;
    final_r   <= final_nxt;
  end

endmodule

`default_nettype wire

### hdl/smmr_check.sv
// Port-level checker for the series statistics block, bound to the top level.
`default_nettype none

module smmr_check (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [smmr_pkg::TOTAL_W-1:0]  out_sample_total,
  input wire logic [smmr_pkg::MEAN_W-1:0]   out_mean_value,
  input wire logic                          out_run_found,
  input wire logic [smmr_pkg::POS_W-1:0]    out_run_first,
  input wire logic [smmr_pkg::POS_W-1:0]    out_run_final
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample_total)
      && $stable(out_mean_value) && $stable(out_run_first) && $stable(out_run_final))
    else $error("result changed while stalled");

  // No result straight out of reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A new result only appears after the block was busy with the last sample
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a preceding busy cycle");

  // No run means zero run indices
  a_no_run_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_run_found |-> out_run_first == '0 && out_run_final == '0)
    else $error("run indices set without a run");

endmodule

bind series_min_max_mean_run smmr_check u_smmr_check (.*);

`default_nettype wire

### tb/sv/tb_top.sv
// Testbench for the series min/max/mean/longest-run statistics block.
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_SAMPLES    = smmr_pkg::DEF_MAX_SAMPLES;
  localparam int SETTLE_CYCLES  = 64;     // beyond one sample plus the division
  localparam int HOLD_CYCLES    = 1500;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PRINT_LIMIT    = 40;

  // One input transfer
  typedef struct packed {
    logic [smmr_pkg::SAMPLE_W-1:0] sample;
    logic                          last;
  } sample_item_t;

  // One series summary
  typedef struct packed {
    logic [smmr_pkg::TOTAL_W-1:0] total;
    logic [smmr_pkg::POS_W-1:0]   min_pos;
    logic [smmr_pkg::POS_W-1:0]   max_pos;
    logic [smmr_pkg::MEAN_W-1:0]  mean;
    logic                         found;
    logic [smmr_pkg::POS_W-1:0]   run_begin;
    logic [smmr_pkg::POS_W-1:0]   run_end;
  } summary_t;

  // How the sample values of a series are drawn
  typedef enum int {
    MIX_UNIFORM,
    MIX_NEAR_THR,
    MIX_TINY,
    MIX_RAILS,
    MIX_ANY
  } value_mix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [smmr_pkg::SAMPLE_W-1:0]   in_step_sample = '0;
  logic                            in_last_sample = 1'b0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [smmr_pkg::TOTAL_W-1:0]    out_sample_total;
  logic [smmr_pkg::POS_W-1:0]      out_min_position;
  logic [smmr_pkg::POS_W-1:0]      out_max_position;
  logic [smmr_pkg::MEAN_W-1:0]     out_mean_value;
  logic                            out_run_found;
  logic [smmr_pkg::POS_W-1:0]      out_run_first;
  logic [smmr_pkg::POS_W-1:0]      out_run_final;
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [smmr_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [smmr_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [smmr_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;

  series_min_max_mean_run dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_step_sample   (in_step_sample),
    .in_last_sample   (in_last_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample_total (out_sample_total),
    .out_min_position (out_min_position),
    .out_max_position (out_max_position),
    .out_mean_value   (out_mean_value),
    .out_run_found    (out_run_found),
    .out_run_first    (out_run_first),
    .out_run_final    (out_run_final),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sample_item_t pend_q[$];
  summary_t     summary_q[$];

  int unsigned send_gap_pct = 0;
  int unsigned recv_gap_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatch_count = 0;

  // Shadow of the threshold register and of the series statistics
  logic [smmr_pkg::THR_W-1:0]    run_thr = smmr_pkg::THR_RESET;
  logic [smmr_pkg::TOTAL_W-1:0]  ser_count = '0;
  logic [smmr_pkg::SAMPLE_W-1:0] ser_min = '0;
  logic [smmr_pkg::POS_W-1:0]    ser_min_pos = '0;
  logic [smmr_pkg::SAMPLE_W-1:0] ser_max = '0;
  logic [smmr_pkg::POS_W-1:0]    ser_max_pos = '0;
  logic [25:0]                   ser_sum = '0;
  logic [smmr_pkg::TOTAL_W-1:0]  ser_run_start = '0;
  logic [smmr_pkg::TOTAL_W-1:0]  ser_best_len = '0;
  logic [smmr_pkg::POS_W-1:0]    ser_best_first = '0;
  logic [smmr_pkg::POS_W-1:0]    ser_best_last = '0;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT) $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  // Fold one accepted sample into the statistics; on the last one, queue the summary
  task automatic fold_sample(input logic [smmr_pkg::SAMPLE_W-1:0] s, input logic last);
    logic [smmr_pkg::TOTAL_W-1:0] idx;
    logic [smmr_pkg::TOTAL_W-1:0] len;
    int unsigned                  q;
    int unsigned                  r;
    summary_t                     res;
    if (ser_count < MAX_SAMPLES) begin
      idx = ser_count;
      if (idx == 0 || s < ser_min) begin
        ser_min     = s;
        ser_min_pos = idx[smmr_pkg::POS_W-1:0];
      end
      if (idx == 0 || s > ser_max) begin
        ser_max     = s;
        ser_max_pos = idx[smmr_pkg::POS_W-1:0];
      end
      ser_sum = ser_sum + s;
      if (s > run_thr) begin
        len = idx - ser_run_start + 1'b1;
        // strictly longer only: the earliest of equal runs stays
        if (len > ser_best_len) begin
          ser_best_len   = len;
          ser_best_first = ser_run_start[smmr_pkg::POS_W-1:0];
          ser_best_last  = idx[smmr_pkg::POS_W-1:0];
        end
      end else begin
        ser_run_start = idx + 1'b1;
      end
      ser_count = idx + 1'b1;
    end
    if (last) begin
      // mean rounded to nearest, ties to even
      q = int'(ser_sum) / int'(ser_count);
      r = int'(ser_sum) % int'(ser_count);
      if (2 * r > ser_count || (2 * r == ser_count && q[0])) q++;
      res.total     = ser_count;
      res.min_pos   = ser_min_pos;
      res.max_pos   = ser_max_pos;
      res.mean      = q[smmr_pkg::MEAN_W-1:0];
      res.found     = (ser_best_len != 0);
      res.run_begin = res.found ? ser_best_first : '0;
      res.run_end   = res.found ? ser_best_last : '0;
      summary_q.push_back(res);
      ser_count      = '0;
      ser_min        = '0;
      ser_min_pos    = '0;
      ser_max        = '0;
      ser_max_pos    = '0;
      ser_sum        = '0;
      ser_run_start  = '0;
      ser_best_len   = '0;
      ser_best_first = '0;
      ser_best_last  = '0;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // Driver: offer the next pending sample once the previous transfer is done
  always @(posedge clk) begin : drive_proc
    sample_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) fold_sample(in_step_sample, in_last_sample);
      if (pend_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        nxt = pend_q.pop_front();
        in_valid       <= 1'b1;
        in_step_sample <= nxt.sample;
        in_last_sample <= nxt.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each result transfer and drive the receiver stall
  always @(posedge clk) begin : monitor_proc
    summary_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (summary_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result, sample_total %0d", out_sample_total));
        end else begin
          want = summary_q.pop_front();
          check_field("sample_total", 32'(out_sample_total), 32'(want.total));
          check_field("min_position", 32'(out_min_position), 32'(want.min_pos));
          check_field("max_position", 32'(out_max_position), 32'(want.max_pos));
          check_field("mean_value", 32'(out_mean_value), 32'(want.mean));
          check_field("run_found", 32'(out_run_found), 32'(want.found));
          check_field("run_first", 32'(out_run_first), 32'(want.run_begin));
          check_field("run_final", 32'(out_run_final), 32'(want.run_end));
        end
      end
      // one long hold-off on request, otherwise random stalls
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_gap_pct);
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_sample(input int unsigned s, input logic last);
    sample_item_t it;
    it.sample = s[smmr_pkg::SAMPLE_W-1:0];
    it.last   = last;
    pend_q.push_back(it);
  endtask

  function automatic logic [smmr_pkg::SAMPLE_W-1:0] pick_sample(input value_mix_t mix);
    int v;
    case (mix)
      MIX_NEAR_THR: begin
        v = int'(run_thr) + int'($urandom_range(0, 6)) - 3;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
      end
      MIX_TINY:  v = $urandom_range(0, 3);
      MIX_RAILS: v = $urandom_range(0, 1) ? 65535 : 0;
      default:   v = $urandom_range(0, 65535);
    endcase
    return v[smmr_pkg::SAMPLE_W-1:0];
  endfunction

  task automatic queue_series(input int n, input value_mix_t mix);
    value_mix_t m;
    for (int i = 0; i < n; i++) begin
      m = (mix == MIX_ANY) ? value_mix_t'($urandom_range(0, 3)) : mix;
      push_sample(32'(pick_sample(m)), i == n - 1);
    end
  endtask

  // Mostly short series, some longer ones
  task automatic queue_random(input int items);
    int cnt;
    int n;
    cnt = 0;
    while (cnt < items) begin
      n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 40);
      queue_series(n, value_mix_t'($urandom_range(0, 4)));
      cnt += n;
    end
  endtask

  // Wait until every sample is sent and every summary has come, then let the block settle
  task automatic drain_block();
    do @(negedge clk);
    while (pend_q.size() != 0 || in_valid || summary_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle
  task automatic write_threshold(input logic [smmr_pkg::THR_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= smmr_pkg::CFG_ADDR_W'(smmr_pkg::REG_RUN_THRESHOLD) << 2;
    pwdata  <= smmr_pkg::CFG_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    run_thr = value;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset threshold
    send_gap_pct = 16;
    recv_gap_pct = 63;
    push_sample(0, 1'b1);                 // single sample at zero
    push_sample(65535, 1'b1);             // single sample at full scale, one-sample run
    push_sample(1, 1'b0);                 // mean 1.5 rounds up to even
    push_sample(2, 1'b1);
    push_sample(0, 1'b0);                 // mean 0.5 rounds down to even
    push_sample(1, 1'b1);
    push_sample(600, 1'b0);               // equal-length runs: earliest kept
    push_sample(600, 1'b0);
    push_sample(7, 1'b0);
    push_sample(501, 1'b0);
    push_sample(501, 1'b0);
    push_sample(500, 1'b0);               // equal to threshold breaks the run
    push_sample(9000, 1'b0);
    push_sample(9000, 1'b1);              // repeated max keeps first index
    push_sample(5, 1'b0);
    push_sample(5, 1'b0);
    push_sample(3, 1'b0);
    push_sample(3, 1'b0);
    push_sample(65535, 1'b0);
    push_sample(0, 1'b0);
    push_sample(0, 1'b1);                 // repeated min keeps first index
    push_sample(501, 1'b0);
    push_sample(500, 1'b1);
    drain_block();

    write_threshold('0);
    queue_random(150);
    drain_block();

    write_threshold('1);                  // no sample can exceed it
    queue_random(100);
    drain_block();

    send_gap_pct = 63;
    recv_gap_pct = 16;
    write_threshold(smmr_pkg::THR_W'($urandom_range(0, 65535)));
    queue_random(150);
    drain_block();

    write_threshold(smmr_pkg::THR_W'(1));
    queue_random(100);
    drain_block();

    // No idling; long receiver hold-off so the block backs up
    send_gap_pct = 0;
    recv_gap_pct = 0;
    write_threshold(smmr_pkg::THR_W'($urandom_range(0, 65535)));
    hold_req = 1'b1;
    queue_random(200);
    drain_block();

    // Mid-scale threshold
    write_threshold(smmr_pkg::THR_W'(32768));
    queue_random(150);
    drain_block();

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### series_min_max_mean_run.f
hdl/smmr_pkg.sv
hdl/smmr_alu.sv
hdl/smmr_cfg.sv
hdl/series_min_max_mean_run.sv
hdl/smmr_check.sv
tb/sv/tb_top.sv
